FILE: hdl/brle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length encoder package
// Shared types and fixed constants of the encoder: sequencer states, the
// emit and grant bundles between the sequencer and the output stage.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int BYTE_W       = 8;
  localparam int HDR_W        = 16;
  localparam int RESULT_LIMIT = 24;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NEXT,
    S_BLK_HLO,
    S_BLK_HHI,
    S_BLK_DAT,
    S_RUN_HLO,
    S_RUN_HHI,
    S_RUN_SYM,
    S_CPY_RD,
    S_CPY_WR,
    S_FIN
  } brle_state_t;

  // sequencer -> output stage
  typedef struct packed {
    logic              put;
    logic [BYTE_W-1:0] data;
    logic              fin;
    logic              fin_last;
  } brle_emit_t;

  // output stage -> sequencer
  typedef struct packed {
    logic put_ok;
    logic fin_ok;
  } brle_grant_t;

endpackage

FILE: hdl/brle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data. Read data holds
// while no read is issued.
// ----------------------------------------------------------------------------
module brle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 18
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/brle_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length encoder sequencer
// Holds the encoder state and the literal buffer, decides the jobs of each
// input byte and steps through them one output byte per cycle while granted.
// ----------------------------------------------------------------------------
module brle_seq #(
  parameter int MIN_RUN_LEN  = 3,
  parameter int MAX_COPY_LEN = 16,
  parameter int MAX_READ_LEN = 18,
  parameter int MAX_RUN_LEN  = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [7:0]             in_data,
  input  logic                   in_last,
  output logic                   idle,
  output brle_pkg::brle_emit_t   emit,
  input  brle_pkg::brle_grant_t  grant
);

  import brle_pkg::*;

  localparam int FILL_MAX   = (MAX_RUN_LEN > MAX_READ_LEN) ? MAX_RUN_LEN : MAX_READ_LEN;
  localparam int FILL_W     = $clog2(FILL_MAX + 1);
  localparam int ADDR_W     = $clog2(MAX_READ_LEN);
  localparam int LEN_W      = $clog2(MAX_READ_LEN + 1);
  localparam int REP_W      = $clog2(MIN_RUN_LEN + 1);
  localparam int FULL_N     = (MAX_COPY_LEN < MAX_READ_LEN) ? MAX_COPY_LEN : MAX_READ_LEN;
  localparam int FULL_REST  = MAX_READ_LEN - FULL_N;
  localparam bit RUN_AT_MIN = (MIN_RUN_LEN >= MAX_RUN_LEN);

  brle_state_t state_r, state_nxt;

  // control state
  logic              in_run_r;
  logic [FILL_W-1:0] fill_r;
  logic [REP_W-1:0]  rep_r;
  logic [7:0]        sym_r;
  logic              do_blk_r, do_run_r, do_cpy_r, last_r;
  logic [CNT_W-1:0]  res_cnt_r;

  // job payload
  logic [7:0]        prev_r;
  logic [ADDR_W-1:0] blk_addr_r;
  logic [LEN_W-1:0]  blk_len_r;
  logic [LEN_W-1:0]  split_left_r;
  logic [HDR_W-1:0]  run_hdr_r;
  logic [7:0]        run_sym_r;
  logic [ADDR_W-1:0] cp_src_r, cp_dst_r;
  logic [LEN_W-1:0]  cp_left_r;
  logic              step_last_r;

  // accept decisions
  logic              in_fire;
  logic [FILL_W-1:0] fill_inc;
  logic [REP_W-1:0]  rep_new;
  logic              acc_in_run, acc_do_blk, acc_do_run, acc_do_cpy;
  logic [FILL_W-1:0] acc_fill, hdr_fill;
  logic [REP_W-1:0]  acc_rep;
  logic [7:0]        acc_sym;
  logic [LEN_W-1:0]  acc_blk_len;
  logic [HDR_W-1:0]  acc_run_hdr;

  // end-of-stream split and block helpers
  logic [LEN_W-1:0]  last_len, last_left, split_len;
  logic [HDR_W-1:0]  blk_hdr;

  // output side
  logic              emit_st, suppress, emit_go;

  // buffer port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  brle_ram #(
    .WIDTH(8),
    .DEPTH(MAX_READ_LEN)
  ) u_buf (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign idle     = (state_r == S_IDLE);
  assign in_fire  = in_valid && idle;
  assign fill_inc = fill_r + FILL_W'(1);
  assign suppress = (res_cnt_r >= CNT_W'(RESULT_LIMIT));
  assign emit_st  = (state_r == S_BLK_HLO) || (state_r == S_BLK_HHI) ||
                    (state_r == S_BLK_DAT) || (state_r == S_RUN_HLO) ||
                    (state_r == S_RUN_HHI) || (state_r == S_RUN_SYM);
  assign emit_go  = emit_st && (suppress || grant.put_ok);
  assign blk_hdr  = HDR_W'(blk_len_r) - HDR_W'(1);

  assign last_len  = (int'(fill_r) < MAX_COPY_LEN) ? LEN_W'(fill_r) : LEN_W'(MAX_COPY_LEN);
  assign last_left = LEN_W'(fill_r) - last_len;
  assign split_len = (int'(split_left_r) < MAX_COPY_LEN) ? split_left_r
                                                         : LEN_W'(MAX_COPY_LEN);

  // trailing equal bytes of the buffer, saturated at the run threshold
  always_comb begin
    if ((rep_r != '0) && (prev_r == in_data)) begin
      rep_new = (int'(rep_r) >= MIN_RUN_LEN) ? rep_r : rep_r + REP_W'(1);
    end else begin
      rep_new = REP_W'(1);
    end
  end

  // decide the jobs of an accepted byte and the state it leaves
  always_comb begin
    acc_in_run  = in_run_r;
    acc_fill    = fill_r;
    acc_rep     = rep_r;
    acc_sym     = sym_r;
    acc_do_blk  = 1'b0;
    acc_do_run  = 1'b0;
    acc_do_cpy  = 1'b0;
    acc_blk_len = '0;
    hdr_fill    = fill_r;
    if (in_run_r) begin
      if (in_data == sym_r) begin
        if (int'(fill_inc) >= MAX_RUN_LEN) begin
          acc_do_run = 1'b1;
          hdr_fill   = fill_inc;
          acc_in_run = 1'b0;
          acc_fill   = '0;
          acc_rep    = '0;
        end else begin
          acc_fill = fill_inc;
        end
      end else begin
        // breaker byte closes the run and opens a new buffer
        acc_do_run = 1'b1;
        acc_in_run = 1'b0;
        acc_fill   = FILL_W'(1);
        acc_rep    = REP_W'(1);
      end
    end else if (int'(rep_new) >= MIN_RUN_LEN) begin
      acc_blk_len = LEN_W'(fill_inc - FILL_W'(MIN_RUN_LEN));
      acc_do_blk  = (acc_blk_len != '0);
      acc_in_run  = 1'b1;
      acc_sym     = in_data;
      acc_fill    = FILL_W'(MIN_RUN_LEN);
      acc_rep     = '0;
      if (RUN_AT_MIN) begin
        acc_do_run = 1'b1;
        hdr_fill   = FILL_W'(MIN_RUN_LEN);
        acc_in_run = 1'b0;
        acc_fill   = '0;
      end
    end else if (int'(fill_inc) >= MAX_READ_LEN) begin
      acc_blk_len = LEN_W'(FULL_N);
      acc_do_blk  = 1'b1;
      acc_do_cpy  = (FULL_REST != 0);
      acc_fill    = FILL_W'(FULL_REST);
      acc_rep     = (int'(rep_new) > FULL_REST) ? REP_W'(FULL_REST) : rep_new;
    end else begin
      acc_fill = fill_inc;
      acc_rep  = rep_new;
    end
    acc_run_hdr = HDR_W'(MIN_RUN_LEN - 1) - HDR_W'(hdr_fill);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_NEXT;
      end
      S_NEXT: begin
        priority if (do_blk_r) state_nxt = S_BLK_HLO;
        else if (do_run_r)     state_nxt = S_RUN_HLO;
        else if (do_cpy_r)     state_nxt = S_CPY_RD;
        else if (last_r)       state_nxt = S_NEXT;
        else                   state_nxt = S_FIN;
      end
      S_BLK_HLO: begin
        if (emit_go) state_nxt = S_BLK_HHI;
      end
      S_BLK_HHI: begin
        if (emit_go) state_nxt = S_BLK_DAT;
      end
      S_BLK_DAT: begin
        if (emit_go && (blk_len_r == LEN_W'(1))) begin
          state_nxt = (split_left_r != '0) ? S_BLK_HLO : S_NEXT;
        end
      end
      S_RUN_HLO: begin
        if (emit_go) state_nxt = S_RUN_HHI;
      end
      S_RUN_HHI: begin
        if (emit_go) state_nxt = S_RUN_SYM;
      end
      S_RUN_SYM: begin
        if (emit_go) state_nxt = S_NEXT;
      end
      S_CPY_RD: state_nxt = S_CPY_WR;
      S_CPY_WR: begin
        state_nxt = (cp_left_r == LEN_W'(1)) ? S_NEXT : S_CPY_RD;
      end
      S_FIN: begin
        if (grant.fin_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs: emit bundle and buffer port
  always_comb begin
    emit      = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = in_data;
    ram_re    = 1'b0;
    ram_raddr = blk_addr_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ram_we    = !in_run_r || (in_data != sym_r);
          ram_waddr = in_run_r ? '0 : fill_r[ADDR_W-1:0];
        end
      end
      S_BLK_HLO: emit.data = blk_hdr[7:0];
      S_BLK_HHI: begin
        emit.data = blk_hdr[15:8];
        ram_re    = emit_go;
      end
      S_BLK_DAT: begin
        emit.data = ram_rdata;
        ram_re    = emit_go && (blk_len_r > LEN_W'(1));
      end
      S_RUN_HLO: emit.data = run_hdr_r[7:0];
      S_RUN_HHI: emit.data = run_hdr_r[15:8];
      S_RUN_SYM: emit.data = run_sym_r;
      S_CPY_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cp_src_r;
      end
      S_CPY_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cp_dst_r;
        ram_wdata = ram_rdata;
      end
      S_FIN: begin
        emit.fin      = 1'b1;
        emit.fin_last = step_last_r;
      end
      S_NEXT: ;
      default: ;
    endcase
    emit.put = emit_st && !suppress;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_run_r  <= 1'b0;
      fill_r    <= '0;
      rep_r     <= '0;
      sym_r     <= '0;
      do_blk_r  <= 1'b0;
      do_run_r  <= 1'b0;
      do_cpy_r  <= 1'b0;
      last_r    <= 1'b0;
      res_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        in_run_r  <= acc_in_run;
        fill_r    <= acc_fill;
        rep_r     <= acc_rep;
        sym_r     <= acc_sym;
        do_blk_r  <= acc_do_blk;
        do_run_r  <= acc_do_run;
        do_cpy_r  <= acc_do_cpy;
        last_r    <= in_last;
        res_cnt_r <= '0;
      end else if (state_r == S_NEXT) begin
        priority if (do_blk_r) begin
          do_blk_r <= 1'b0;
        end else if (do_run_r) begin
          do_run_r <= 1'b0;
        end else if (do_cpy_r) begin
          do_cpy_r <= 1'b0;
        end else if (last_r) begin
          // flush the open run or the buffer, then start a fresh stream
          do_run_r <= in_run_r;
          do_blk_r <= !in_run_r && (fill_r != '0);
          last_r   <= 1'b0;
          in_run_r <= 1'b0;
          fill_r   <= '0;
          rep_r    <= '0;
          sym_r    <= '0;
        end else begin
          last_r <= 1'b0;
        end
      end else if (emit.put && grant.put_ok) begin
        res_cnt_r <= res_cnt_r + CNT_W'(1);
      end
    end
  end

  // job payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      prev_r       <= in_data;
      blk_addr_r   <= '0;
      blk_len_r    <= acc_blk_len;
      split_left_r <= '0;
      run_hdr_r    <= acc_run_hdr;
      run_sym_r    <= in_run_r ? sym_r : in_data;
      cp_src_r     <= ADDR_W'(FULL_N);
      cp_dst_r     <= '0;
      cp_left_r    <= LEN_W'(FULL_REST);
      step_last_r  <= in_last;
    end else begin
      unique case (state_r)
        S_NEXT: begin
          if (!do_blk_r && !do_run_r && !do_cpy_r && last_r) begin
            blk_addr_r   <= '0;
            blk_len_r    <= last_len;
            split_left_r <= last_left;
            run_hdr_r    <= HDR_W'(MIN_RUN_LEN - 1) - HDR_W'(fill_r);
            run_sym_r    <= sym_r;
          end
        end
        S_BLK_HHI: begin
          if (emit_go) blk_addr_r <= blk_addr_r + ADDR_W'(1);
        end
        S_BLK_DAT: begin
          if (emit_go) begin
            if (blk_len_r > LEN_W'(1)) begin
              blk_len_r  <= blk_len_r - LEN_W'(1);
              blk_addr_r <= blk_addr_r + ADDR_W'(1);
            end else begin
              blk_len_r    <= split_len;
              split_left_r <= split_left_r - split_len;
            end
          end
        end
        S_CPY_RD: cp_src_r <= cp_src_r + ADDR_W'(1);
        S_CPY_WR: begin
          cp_dst_r  <= cp_dst_r + ADDR_W'(1);
          cp_left_r <= cp_left_r - LEN_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/byte_run_length_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length encoder unit
// PackBits-style encoder with 16-bit little-endian block headers.
// ----------------------------------------------------------------------------
// Each input transfer carries one raw byte; in_tlast marks the last byte of a
// stream. Literal bytes collect in a small buffer RAM. Once MIN_RUN_LEN equal
// bytes end the buffer, the literals before them go out as a literal block
// (header length-1, then the bytes) and a run is counted up to MAX_RUN_LEN; a
// run goes out as header (MIN_RUN_LEN-1)-length and its symbol. A full buffer
// sends its first MAX_COPY_LEN bytes; the last byte of a stream flushes the
// open run or the buffer in blocks of at most MAX_COPY_LEN bytes and starts a
// new stream. Each output transfer carries one byte; out_tuser marks the last
// byte produced by an input byte and out_tlast the final byte of a stream. At
// most 24 bytes are produced per input byte; any beyond that are dropped.
// Flow: the unit takes one byte, then works on it alone with a single output
// byte sequencer and one buffer port. Each byte is accepted and dispatched,
// then the output bytes and pending jobs (block, run or buffer move; a split
// end-of-stream flush counts as one job) follow, each job with a return to
// dispatch; a burst close ends the byte, and a stream's last byte adds a
// dispatch. Buffer moves read, then write each byte; output backpressure stalls.
// ----------------------------------------------------------------------------
module byte_run_length_encoder_unit #(
  parameter int MIN_RUN_LEN  = 3,
  parameter int MAX_COPY_LEN = 16,
  parameter int MAX_READ_LEN = 18,
  parameter int MAX_RUN_LEN  = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  // output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [0:0] out_tuser,  // [0] burst_end
  output logic       out_tlast   // stream_end
);

  import brle_pkg::*;

  brle_emit_t  emit;
  brle_grant_t grant;
  logic        seq_idle;

  // one byte held back until the sequencer knows whether it closes the burst
  logic              pend_v_r;
  logic [BYTE_W-1:0] pend_data_r;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_burst_r, out_stream_r;

  logic out_free, put_fire, fin_fire, load_out;

  brle_seq #(
    .MIN_RUN_LEN (MIN_RUN_LEN),
    .MAX_COPY_LEN(MAX_COPY_LEN),
    .MAX_READ_LEN(MAX_READ_LEN),
    .MAX_RUN_LEN (MAX_RUN_LEN)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_data (in_tdata),
    .in_last (in_tlast),
    .idle    (seq_idle),
    .emit    (emit),
    .grant   (grant)
  );

  assign in_tready = seq_idle;

  // the output register is free when empty or being taken this cycle
  assign out_free     = !out_valid_r || out_tready;
  assign grant.put_ok = !pend_v_r || out_free;
  assign grant.fin_ok = !pend_v_r || out_free;

  assign put_fire = emit.put && grant.put_ok;
  assign fin_fire = emit.fin && grant.fin_ok;
  // a new byte pushes the held one out; the burst end releases it flagged
  assign load_out = pend_v_r && (put_fire || fin_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (put_fire) begin
        pend_v_r <= 1'b1;
      end else if (fin_fire) begin
        pend_v_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_fire) begin
      pend_data_r <= emit.data;
    end
    if (load_out) begin
      out_data_r   <= pend_data_r;
      out_burst_r  <= fin_fire;
      out_stream_r <= fin_fire && emit.fin_last;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_burst_r;
  assign out_tlast    = out_stream_r;

endmodule

FILE: sim/byte_run_length_encoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte run-length encoder unit testbench
// Streams raw bytes into the encoder under random idling on both sides and
// checks every coded output byte, with its burst and stream markers, against
// a predictor of the encoder that runs alongside.
// ----------------------------------------------------------------------------
module byte_run_length_encoder_unit_test;
  import brle_pkg::*;

  // encoder sizing, kept at the unit's defaults
  localparam int MIN_RUN_LEN  = 3;
  localparam int MAX_COPY_LEN = 16;
  localparam int MAX_READ_LEN = 18;
  localparam int MAX_RUN_LEN  = 1024;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 10;

  typedef logic [BYTE_W-1:0] octet_t;

  // one coded output byte as it appears on the result channel
  typedef struct packed {
    octet_t value;
    logic   burst_end;
    logic   stream_end;
  } coded_octet_t;

  // --------------------------------------------------------------------------
  // Encoder predictor and expected-byte store
  // --------------------------------------------------------------------------
  class rle_scoreboard;
    octet_t       lit_buf [MAX_READ_LEN];
    int unsigned  fill;
    bit           run_open;
    octet_t       run_sym;
    coded_octet_t burst[$];
    coded_octet_t awaited[$];
    int unsigned  mismatches;
    int unsigned  inputs_seen;
    int unsigned  outputs_seen;
    int unsigned  streams_closed;
    int unsigned  silent_inputs;

    function new();
      foreach (lit_buf[i]) lit_buf[i] = '0;
      fill           = 0;
      run_open       = 1'b0;
      run_sym        = '0;
      mismatches     = 0;
      inputs_seen    = 0;
      outputs_seen   = 0;
      streams_closed = 0;
      silent_inputs  = 0;
    endfunction

    function void push_octet(octet_t v);
      coded_octet_t c;
      if (burst.size() >= RESULT_LIMIT) return;
      c.value      = v;
      c.burst_end  = 1'b0;
      c.stream_end = 1'b0;
      burst.push_back(c);
    endfunction

    // headers go out low byte first
    function void push_header(int unsigned hdr);
      push_octet(hdr[7:0]);
      push_octet(hdr[15:8]);
    endfunction

    function octet_t buf_at(int unsigned idx);
      return (idx < MAX_READ_LEN) ? lit_buf[idx] : '0;
    endfunction

    function void push_block(int unsigned start, int unsigned len);
      if (len == 0) return;
      push_header(len - 1);
      for (int unsigned i = 0; i < len; i++) push_octet(buf_at(start + i));
    endfunction

    function void push_run();
      push_header((MIN_RUN_LEN - 1 - fill) & 32'h0000_FFFF);
      push_octet(run_sym);
    endfunction

    // Advance the encoder state by one accepted input byte and queue the
    // coded bytes it produces.
    function void note_input(octet_t din, bit closes);
      bit           run_found;
      int unsigned  n;
      int unsigned  chunk;
      coded_octet_t tail;
      burst.delete();
      inputs_seen++;
      if (run_open) begin
        if (din == run_sym) begin
          fill++;
          if (fill >= MAX_RUN_LEN) begin
            push_run();
            run_open = 1'b0;
            fill     = 0;
          end
        end else begin
          // run breaker: close the run, start a fresh literal buffer
          push_run();
          run_open   = 1'b0;
          lit_buf[0] = din;
          fill       = 1;
        end
      end else begin
        run_found = 1'b0;
        if (fill < MAX_READ_LEN) lit_buf[fill] = din;
        fill++;
        if (fill >= MIN_RUN_LEN) begin
          run_found = 1'b1;
          for (int unsigned k = 2; k <= MIN_RUN_LEN; k++)
            if (buf_at(fill - k) != din) run_found = 1'b0;
        end
        if (run_found) begin
          push_block(0, fill - MIN_RUN_LEN);
          run_open = 1'b1;
          run_sym  = din;
          fill     = MIN_RUN_LEN;
          if (fill >= MAX_RUN_LEN) begin
            push_run();
            run_open = 1'b0;
            fill     = 0;
          end
        end else if (fill >= MAX_READ_LEN) begin
          // full buffer: send the head, slide the rest to the front
          n = (fill < MAX_COPY_LEN) ? fill : MAX_COPY_LEN;
          push_block(0, n);
          fill -= n;
          for (int unsigned k = 0; k < fill; k++) lit_buf[k] = buf_at(n + k);
        end
      end

      if (closes) begin
        if (run_open) begin
          push_run();
        end else begin
          for (int unsigned s = 0; s < fill; s += chunk) begin
            chunk = (fill - s > MAX_COPY_LEN) ? MAX_COPY_LEN : fill - s;
            push_block(s, chunk);
          end
        end
        run_open = 1'b0;
        fill     = 0;
        run_sym  = '0;
      end

      if (burst.size() > 0) begin
        tail           = burst[burst.size() - 1];
        tail.burst_end = 1'b1;
        if (closes) begin
          tail.stream_end = 1'b1;
          streams_closed++;
        end
        burst[burst.size() - 1] = tail;
      end else begin
        silent_inputs++;
      end
      foreach (burst[i]) awaited.push_back(burst[i]);
    endfunction

    function void report(string what, coded_octet_t want, coded_octet_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %0d, %s: expected data=%02h user=%b last=%b, got data=%02h user=%b last=%b",
                 mismatches, what, want.value, want.burst_end, want.stream_end,
                 got.value, got.burst_end, got.stream_end);
    endfunction

    // Compare one accepted output byte with the oldest expectation.
    function void check_result(octet_t value, logic burst_end, logic stream_end);
      coded_octet_t want;
      coded_octet_t got;
      got.value      = value;
      got.burst_end  = burst_end;
      got.stream_end = stream_end;
      outputs_seen++;
      if (awaited.size() == 0) begin
        want = '0;
        report("output with nothing pending", want, got);
      end else begin
        want = awaited.pop_front();
        if (got !== want) report($sformatf("output byte %0d", outputs_seen), want, got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Unit under test
  // --------------------------------------------------------------------------
  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;   // [7:0] data_byte
  logic       in_tlast   = 1'b0; // last_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] out_byte
  logic [0:0] out_tuser;         // [0] burst_end
  logic       out_tlast;         // stream_end

  byte_run_length_encoder_unit #(
    .MIN_RUN_LEN (MIN_RUN_LEN),
    .MAX_COPY_LEN(MAX_COPY_LEN),
    .MAX_READ_LEN(MAX_READ_LEN),
    .MAX_RUN_LEN (MAX_RUN_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  rle_scoreboard board;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   stim_count     = 0;
  int unsigned   cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: end the run if it hangs anywhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d coded bytes still pending",
               cycle_count, board.awaited.size());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stall at random and check every output transfer. Both the
  // handshake and the data are sampled with their values from before the edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata, out_tuser[0], out_tlast);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Offer one byte, with random idle cycles ahead of it, and hold it until the
  // encoder takes the transfer. Valid stays high into the next byte unless an
  // idle cycle follows.
  task automatic send_octet(input octet_t value, input bit closes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= closes;
    do @(posedge clk); while (!in_tready);
    board.note_input(value, closes);
    stim_count++;
  endtask

  task automatic run_directed();
    // lone literal closing its stream
    send_octet(8'h00, 1'b0 | 1'b1);
    // bare run with no literals ahead of it, flushed by the last byte
    send_octet(8'hFF, 1'b0);
    send_octet(8'hFF, 1'b0);
    send_octet(8'hFF, 1'b1);
    // literal, then a run broken by a new byte, then a two-byte block
    send_octet(8'h12, 1'b0);
    send_octet(8'h34, 1'b0);
    send_octet(8'h34, 1'b0);
    send_octet(8'h34, 1'b0);
    send_octet(8'h56, 1'b0);
    send_octet(8'hAA, 1'b1);
    // fill the literal buffer: the head block goes at once, the rest at the
    // last byte
    for (int i = 0; i < MAX_READ_LEN; i++)
      send_octet(octet_t'(8'h80 + i * 7), i == MAX_READ_LEN - 1);
  endtask

  // One well-formed piece of a stream with random content: literal stretches,
  // runs of varied length, near-runs from a two-symbol alphabet, or a long
  // stretch of at least MAX_READ_LEN-1 bytes. About a third close the stream.
  task automatic random_segment();
    octet_t      seg[$];
    int unsigned kind;
    int unsigned len;
    octet_t      sym;
    bit          closes;
    kind = $urandom_range(9);
    sym  = octet_t'($urandom_range(255));
    case (kind)
      0, 1, 2, 3: begin
        len = $urandom_range(1, 12);
        repeat (len) seg.push_back(octet_t'($urandom_range(255)));
      end
      4, 5, 6: begin
        len = $urandom_range(2, 12);
        repeat (len) seg.push_back(sym);
      end
      7, 8: begin
        len = $urandom_range(3, 10);
        repeat (len) seg.push_back(sym ^ octet_t'($urandom_range(1)));
      end
      default: begin
        len = $urandom_range(MAX_READ_LEN - 1, MAX_READ_LEN + 6);
        repeat (len) seg.push_back(octet_t'($urandom_range(255)));
      end
    endcase
    closes = ($urandom_range(99) < 33);
    foreach (seg[i]) send_octet(seg[i], closes && (i == seg.size() - 1));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = stim_count + count;
    while (stim_count < target) random_segment();
  endtask

  initial begin
    board = new();
    send_idle_pct  = 18;
    recv_stall_pct = 70;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalled
    run_directed();
    run_random(22);

    // sender mostly idle, receiver mostly ready
    send_idle_pct  = 70;
    recv_stall_pct = 18;
    run_random(22);

    // back to back on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(22);
    // close the final stream so nothing stays buffered
    send_octet(octet_t'($urandom_range(255)), 1'b1);
    in_tvalid <= 1'b0;

    // drain: wait out every expected byte, then watch for strays
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("encoded %0d input bytes into %0d checked output bytes over %0d streams",
             board.inputs_seen, board.outputs_seen, board.streams_closed);
    $display("%0d inputs produced no output, %0d mismatches, %0d bytes left pending",
             board.silent_inputs, board.mismatches, board.awaited.size());
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
